FILE: rtl/core/pmq_pkg.sv
// Shared types and constants for the per-node max-priority queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pmq_pkg;

	// Default sizing, handed to the top-level parameters.
	localparam int NODES_DEF    = 16;
	localparam int CAPACITY_DEF = 16;

	// Fixed field widths.
	localparam int OPW   = 2;
	localparam int NIDW  = 4;
	localparam int VALW  = 32;
	localparam int ECW   = 5;
	localparam int TOTW  = 16;

	// Saturation point of the push total.
	localparam logic [TOTW-1:0] TOTAL_MAX = 16'hFFFF;

	// Operation codes.
	localparam logic [OPW-1:0] OP_PUSH = 2'd0;
	localparam logic [OPW-1:0] OP_POP  = 2'd1;
	localparam logic [OPW-1:0] OP_PEEK = 2'd2;

	// One finished result word, as the sequencer hands it to the output register.
	typedef struct packed {
		logic signed [VALW-1:0] head;
		logic                   empty;
		logic                   full;
		logic [ECW-1:0]         count;
		logic [TOTW-1:0]        total;
	} pmq_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/pmq_entry_ram.sv
// Entry store: one write port and one registered read port.
// Depends on pmq_pkg for the value width.
`timescale 1ns / 1ps
`default_nettype none

module pmq_entry_ram
	import pmq_pkg::*;
#(
	parameter int DEPTH = NODES_DEF * CAPACITY_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [AW-1:0]          waddr,
	input  wire logic signed [VALW-1:0] wdata,
	input  wire logic                   re,
	input  wire logic [AW-1:0]          raddr,
	output logic signed [VALW-1:0]      rdata
);

	logic signed [VALW-1:0] mem [DEPTH];
	logic signed [VALW-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/pmq_node_table.sv
// Per-node fill counts and push totals, with a valid bit per node so that
// a node never written reads as zero. Depends on pmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmq_node_table
	import pmq_pkg::*;
#(
	parameter int NODES = NODES_DEF,
	parameter int NW    = (NODES > 1) ? $clog2(NODES) : 1,
	parameter int CW    = 5
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            re,
	input  wire logic [NW-1:0]   raddr,
	output logic [CW-1:0]        rcount,
	output logic [TOTW-1:0]      rtotal,
	input  wire logic            we,
	input  wire logic [NW-1:0]   waddr,
	input  wire logic [CW-1:0]   wcount,
	input  wire logic [TOTW-1:0] wtotal
);

	logic [CW-1:0]   count_mem [NODES];
	logic [TOTW-1:0] total_mem [NODES];
	logic [NODES-1:0] valid_q;
	logic [CW-1:0]   rcount_q;
	logic [TOTW-1:0] rtotal_q;
	logic            rvalid_q;

	// Valid bits, cleared at once by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Storage write.
	always_ff @(posedge clk) begin
		if (we) begin
			count_mem[waddr] <= wcount;
			total_mem[waddr] <= wtotal;
		end
	end

	// Registered read, valid bit taken alongside.
	always_ff @(posedge clk) begin
		if (re) begin
			rcount_q <= count_mem[raddr];
			rtotal_q <= total_mem[raddr];
			rvalid_q <= valid_q[raddr];
		end
	end

	assign rcount = rvalid_q ? rcount_q : '0;
	assign rtotal = rvalid_q ? rtotal_q : '0;

endmodule

`default_nettype wire

FILE: rtl/core/pmq_ctrl.sv
// Sequencer for the queue operations: the entry-store ports walk the sorted
// insert and the head removal, with one signed comparator for the insert.
// Depends on pmq_pkg; drives pmq_entry_ram and pmq_node_table.
`timescale 1ns / 1ps
`default_nettype none

module pmq_ctrl
	import pmq_pkg::*;
#(
	parameter int NODES    = NODES_DEF,
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int NW       = (NODES > 1) ? $clog2(NODES) : 1,
	parameter int CW       = $clog2(CAPACITY + 1),
	parameter int AW       = (NODES * CAPACITY > 1) ? $clog2(NODES * CAPACITY) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Request side.
	input  wire logic                   req_valid,
	output logic                        req_stall,
	input  wire logic [OPW-1:0]         opcode,
	input  wire logic [NIDW-1:0]        node_index,
	input  wire logic signed [VALW-1:0] push_value,
	// Node table.
	output logic                        tbl_re,
	output logic [NW-1:0]               tbl_raddr,
	input  wire logic [CW-1:0]          tbl_count,
	input  wire logic [TOTW-1:0]        tbl_total,
	output logic                        tbl_we,
	output logic [NW-1:0]               tbl_waddr,
	output logic [CW-1:0]               tbl_wcount,
	output logic [TOTW-1:0]             tbl_wtotal,
	// Entry store.
	output logic                        ent_we,
	output logic [AW-1:0]               ent_waddr,
	output logic signed [VALW-1:0]      ent_wdata,
	output logic                        ent_re,
	output logic [AW-1:0]               ent_raddr,
	input  wire logic signed [VALW-1:0] ent_rdata,
	// Result side.
	input  wire logic                   res_hold,
	output logic                        res_fire,
	output pmq_result_t                 res
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_META  = 3'd1;
	localparam logic [2:0] S_INS   = 3'd2;
	localparam logic [2:0] S_PUT   = 3'd3;
	localparam logic [2:0] S_HEAD  = 3'd4;
	localparam logic [2:0] S_SHIFT = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C  = CW'(1);
	localparam logic [CW-1:0] TWO_C  = CW'(2);

	logic [2:0]             state_q;
	logic [OPW-1:0]         op_q;
	logic [NW-1:0]          node_q;
	logic                   range_q;
	logic signed [VALW-1:0] val_q;
	logic [AW-1:0]          base_q;
	logic [CW-1:0]          cnt_q;
	logic [TOTW-1:0]        tot_q;
	logic [CW-1:0]          pos_q;
	logic signed [VALW-1:0] head_q;
	logic                   empty_q;
	logic                   full_q;
	logic                   accept;
	logic                   in_range;
	logic                   less;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign in_range  = (32'(node_index) < NODES);

	// The single comparator: stored entry against the value being inserted.
	assign less = (ent_rdata < val_q);

	// Node table read at acceptance, write-back when the result leaves.
	assign tbl_re     = accept && in_range;
	assign tbl_raddr  = NW'(node_index);
	assign res_fire   = (state_q == S_FIN) && !res_hold;
	assign tbl_we     = res_fire && range_q;
	assign tbl_waddr  = node_q;
	assign tbl_wcount = cnt_q;
	assign tbl_wtotal = tot_q;

	// Result word.
	assign res.head  = head_q;
	assign res.empty = empty_q;
	assign res.full  = full_q;
	assign res.count = ECW'(cnt_q);
	assign res.total = tot_q;

	// Entry store accesses for each step of the walk.
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = base_q;
		ent_wdata = val_q;
		ent_re    = 1'b0;
		ent_raddr = base_q;
		unique case (state_q)
			S_META: begin
				if (range_q && op_q == OP_PUSH && tbl_count < CAP_C) begin
					if (tbl_count == '0) begin
						ent_we = 1'b1;
					end else begin
						ent_re    = 1'b1;
						ent_raddr = base_q + AW'(tbl_count - ONE_C);
					end
				end else if (range_q && (op_q == OP_POP || op_q == OP_PEEK) &&
						tbl_count != '0) begin
					ent_re = 1'b1;
				end
			end
			S_INS: begin
				ent_we    = 1'b1;
				ent_waddr = base_q + AW'(pos_q);
				if (less) begin
					ent_wdata = ent_rdata;
					if (pos_q > ONE_C) begin
						ent_re    = 1'b1;
						ent_raddr = base_q + AW'(pos_q - TWO_C);
					end
				end
			end
			S_PUT: begin
				ent_we    = 1'b1;
				ent_waddr = base_q + AW'(pos_q);
			end
			S_HEAD: begin
				if (op_q == OP_POP && cnt_q > ONE_C) begin
					ent_re    = 1'b1;
					ent_raddr = base_q + AW'(ONE_C);
				end
			end
			S_SHIFT: begin
				ent_we    = 1'b1;
				ent_waddr = base_q + AW'(pos_q - ONE_C);
				ent_wdata = ent_rdata;
				if ((pos_q + ONE_C) < cnt_q) begin
					ent_re    = 1'b1;
					ent_raddr = base_q + AW'(pos_q + ONE_C);
				end
			end
			default: begin
			end
		endcase
	end

	// Request capture; payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			node_q  <= NW'(node_index);
			val_q   <= push_value;
			base_q  <= AW'(32'(node_index) * CAPACITY);
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			range_q <= 1'b0;
			cnt_q   <= '0;
			tot_q   <= '0;
			pos_q   <= '0;
			head_q  <= '0;
			empty_q <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						range_q <= in_range;
						state_q <= S_META;
					end
				end
				S_META: begin
					head_q  <= '0;
					empty_q <= 1'b0;
					full_q  <= 1'b0;
					cnt_q   <= tbl_count;
					tot_q   <= tbl_total;
					pos_q   <= tbl_count;
					state_q <= S_FIN;
					if (!range_q) begin
						cnt_q <= '0;
						tot_q <= '0;
					end else begin
						case (op_q) inside
							OP_PUSH: begin
								if (tbl_count >= CAP_C) begin
									full_q <= 1'b1;
								end else begin
									cnt_q <= tbl_count + ONE_C;
									tot_q <= (tbl_total == TOTAL_MAX) ? tbl_total :
										tbl_total + 16'd1;
									if (tbl_count != '0) begin
										state_q <= S_INS;
									end
								end
							end
							OP_POP, OP_PEEK: begin
								if (tbl_count == '0) begin
									empty_q <= 1'b1;
								end else begin
									state_q <= S_HEAD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_INS: begin
					// Move the smaller entry down one place, or settle here.
					if (less) begin
						pos_q <= pos_q - ONE_C;
						state_q <= (pos_q > ONE_C) ? S_INS : S_PUT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_PUT: begin
					state_q <= S_FIN;
				end
				S_HEAD: begin
					head_q <= ent_rdata;
					pos_q  <= ONE_C;
					if (op_q != OP_POP) begin
						state_q <= S_FIN;
					end else if (cnt_q > ONE_C) begin
						state_q <= S_SHIFT;
					end else begin
						cnt_q   <= cnt_q - ONE_C;
						state_q <= S_FIN;
					end
				end
				S_SHIFT: begin
					// Close the gap left by the head, one entry a cycle.
					if ((pos_q + ONE_C) < cnt_q) begin
						pos_q <= pos_q + ONE_C;
					end else begin
						cnt_q   <= cnt_q - ONE_C;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!res_hold) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Entry writes stay inside the addressed node's region.
	a_write_in_node: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> (ent_waddr >= base_q) && (32'(ent_waddr - base_q) < CAPACITY))
		else $error("entry write outside the node region");

	// A written-back count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> (tbl_wcount <= CAP_C))
		else $error("node count above capacity");

	// A result never reports empty and full together.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |-> !(res.empty && res.full))
		else $error("empty and full reported together");

	// The insertion walk never runs past the head position.
	a_ins_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |-> (pos_q != '0))
		else $error("insertion walk at position zero");

endmodule

`default_nettype wire

FILE: rtl/core/per_node_max_priority_queue.sv
// Top level of the per-node max-priority queue: sequencer, entry store,
// node table and the result register. Depends on pmq_pkg and its submodules.
//
//   channel   handshake              word fields
//   request   req_valid / req_stall  opcode, node_index, push_value
//   response  rsp_valid / rsp_stall  head_value, was_empty, was_full,
//                                    entry_count, push_total
//
// A push moves one entry per cycle through the entry-store ports until its
// place is found, a pop moves count - 1 entries the same way. The request
// side is stalled while a word is in work. Reset is asynchronous and clears
// the node table at once; entries are never read before they are written.
// A result held by rsp_stall stops the sequencer only when a second result
// is ready to leave.
`timescale 1ns / 1ps
`default_nettype none

module per_node_max_priority_queue
	import pmq_pkg::*;
#(
	parameter int NODES    = NODES_DEF,
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_stall,
	input  wire logic [OPW-1:0]         opcode,
	input  wire logic [NIDW-1:0]        node_index,
	input  wire logic signed [VALW-1:0] push_value,
	output logic                        rsp_valid,
	input  wire logic                   rsp_stall,
	output logic signed [VALW-1:0]      head_value,
	output logic                        was_empty,
	output logic                        was_full,
	output logic [ECW-1:0]              entry_count,
	output logic [TOTW-1:0]             push_total
);

	localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int ED = NODES * CAPACITY;
	localparam int AW = (ED > 1) ? $clog2(ED) : 1;

	logic                   tbl_re;
	logic [NW-1:0]          tbl_raddr;
	logic [CW-1:0]          tbl_count;
	logic [TOTW-1:0]        tbl_total;
	logic                   tbl_we;
	logic [NW-1:0]          tbl_waddr;
	logic [CW-1:0]          tbl_wcount;
	logic [TOTW-1:0]        tbl_wtotal;
	logic                   ent_we;
	logic [AW-1:0]          ent_waddr;
	logic signed [VALW-1:0] ent_wdata;
	logic                   ent_re;
	logic [AW-1:0]          ent_raddr;
	logic signed [VALW-1:0] ent_rdata;
	logic                   res_hold;
	logic                   res_fire;
	pmq_result_t            res;
	pmq_result_t            rsp_q;
	logic                   rsp_valid_q;

	pmq_ctrl #(
		.NODES    (NODES),
		.CAPACITY (CAPACITY),
		.NW       (NW),
		.CW       (CW),
		.AW       (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.opcode     (opcode),
		.node_index (node_index),
		.push_value (push_value),
		.tbl_re     (tbl_re),
		.tbl_raddr  (tbl_raddr),
		.tbl_count  (tbl_count),
		.tbl_total  (tbl_total),
		.tbl_we     (tbl_we),
		.tbl_waddr  (tbl_waddr),
		.tbl_wcount (tbl_wcount),
		.tbl_wtotal (tbl_wtotal),
		.ent_we     (ent_we),
		.ent_waddr  (ent_waddr),
		.ent_wdata  (ent_wdata),
		.ent_re     (ent_re),
		.ent_raddr  (ent_raddr),
		.ent_rdata  (ent_rdata),
		.res_hold   (res_hold),
		.res_fire   (res_fire),
		.res        (res)
	);

	pmq_node_table #(
		.NODES (NODES),
		.NW    (NW),
		.CW    (CW)
	) u_node_table (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (tbl_re),
		.raddr  (tbl_raddr),
		.rcount (tbl_count),
		.rtotal (tbl_total),
		.we     (tbl_we),
		.waddr  (tbl_waddr),
		.wcount (tbl_wcount),
		.wtotal (tbl_wtotal)
	);

	pmq_entry_ram #(
		.DEPTH (ED),
		.AW    (AW)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// Result register: a new word may load as the held one leaves.
	assign res_hold = rsp_valid_q && rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign head_value  = rsp_q.head;
	assign was_empty   = rsp_q.empty;
	assign was_full    = rsp_q.full;
	assign entry_count = rsp_q.count;
	assign push_total  = rsp_q.total;

endmodule

`default_nettype wire
